FILE: sv/lead_compensator_pwm_assert.svh
// assertion macros shared by the checker
`ifndef LEAD_COMPENSATOR_PWM_ASSERT_SVH
`define LEAD_COMPENSATOR_PWM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcp assertion failed");

// next-cycle implication, disabled during reset
`define LCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcp assertion failed");

`endif

FILE: sv/lcp_pkg.sv
package lcp_pkg;

  // fixed block constants
  localparam int PWM_PERIOD     = 9999;
  localparam int ADC_LEVELS     = 1024;
  localparam int COEF_FRAC_BITS = 14;
  localparam int DUTY_MIN       = 2;

  localparam int SAMPLE_W = 10;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int COEF_W   = 16;
  localparam int CMD_W    = 32;
  localparam int DUTY_W   = 14;
  localparam int MUL_A_W  = 17;
  localparam int MUL_B_W  = CMD_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 50;
  localparam int SCALE_SHIFT = $clog2(ADC_LEVELS) + COEF_FRAC_BITS;
  localparam int Q_W      = PROD_W - SCALE_SHIFT;

  // register port
  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS) + 2;
  localparam int DATA_W   = 32;
  localparam int TAP_W    = 3;

  typedef enum logic [$clog2(NUM_REGS)-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_CLOSED_LOOP = 3'd1,
    REG_DRIVE       = 3'd2,
    REG_COEF_B0     = 3'd3,
    REG_COEF_B1     = 3'd4,
    REG_COEF_B2     = 3'd5,
    REG_COEF_A1     = 3'd6,
    REG_COEF_A2     = 3'd7
  } reg_idx_e;

  // multiplier operand pairs, taps in issue order
  typedef enum logic [TAP_W-1:0] {
    MUL_B0    = 3'd0,
    MUL_B1    = 3'd1,
    MUL_B2    = 3'd2,
    MUL_A1    = 3'd3,
    MUL_A2    = 3'd4,
    MUL_SCALE = 3'd5
  } mul_sel_e;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(MUL_A2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_SAT,
    ST_SCALE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0]      setpoint;
    logic                     closed_loop;
    logic [SAMPLE_W-1:0]      drive;
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic     sample_load;
    logic     hist_clear;
    logic     acc_clr;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_add;
    logic     cmd_from_acc;
    logic     cmd_from_drive;
    logic     hist_update;
    logic     out_load;
  } dp_cmd_t;

endpackage

FILE: sv/lead_compensator_pwm.sv
// Second-order lead compensator with PWM duty output. Each accepted sample
// gives exactly one duty beat. In closed-loop mode the error against the
// setpoint runs through b0*e + b1*e1 + b2*e2 - a1*u1 - a2*u2 (Q2.14
// coefficients, command kept with 14 fraction bits, floored and saturated
// to 32 bits); in open-loop mode the drive register is the command and the
// history is cleared. The command is scaled by 9999/1024, truncated and
// clamped to [2, 9999]; clamped flags a clamp. One 17x32 multiplier serves
// all five taps and the scaling: a closed-loop sample runs the five taps,
// a flush, saturation and scaling, an open-loop sample only scaling. The
// input is taken again once the result sits in the output register, and a
// stalled output holds the block after that. The register port is always
// ready; registers live at byte addresses 4*i in list order.
module lead_compensator_pwm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lcp_pkg::SAMPLE_W-1:0] sample_i,
  // duty channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [lcp_pkg::DUTY_W-1:0]   duty_o,
  output logic                         clamped_o,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcp_pkg::ADDR_W-1:0]   paddr,
  input  logic [lcp_pkg::DATA_W-1:0]   pwdata,
  output logic [lcp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  lcp_pkg::cfg_t    cfg;
  lcp_pkg::dp_cmd_t dp_cmd;

  assign pready = 1'b1;

  // configuration registers
  lcp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // sequencer
  lcp_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .closed_loop_i (cfg.closed_loop),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .cmd_o         (dp_cmd)
  );

  // arithmetic and history
  lcp_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (dp_cmd),
    .sample_i  (sample_i),
    .duty_o    (duty_o),
    .clamped_o (clamped_o)
  );

endmodule

FILE: sv/lcp_regs.sv
module lcp_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcp_pkg::ADDR_W-1:0] paddr,
  input  logic [lcp_pkg::DATA_W-1:0] pwdata,
  output logic [lcp_pkg::DATA_W-1:0] prdata,
  output lcp_pkg::cfg_t              cfg_o
);

  lcp_pkg::cfg_t    cfg_q, cfg_d;
  lcp_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx   = lcp_pkg::reg_idx_e'(paddr[lcp_pkg::ADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        lcp_pkg::REG_SETPOINT:    cfg_d.setpoint    = pwdata[lcp_pkg::SAMPLE_W-1:0];
        lcp_pkg::REG_CLOSED_LOOP: cfg_d.closed_loop = pwdata[0];
        lcp_pkg::REG_DRIVE:       cfg_d.drive       = pwdata[lcp_pkg::SAMPLE_W-1:0];
        lcp_pkg::REG_COEF_B0:     cfg_d.coef_b0     = pwdata[lcp_pkg::COEF_W-1:0];
        lcp_pkg::REG_COEF_B1:     cfg_d.coef_b1     = pwdata[lcp_pkg::COEF_W-1:0];
        lcp_pkg::REG_COEF_B2:     cfg_d.coef_b2     = pwdata[lcp_pkg::COEF_W-1:0];
        lcp_pkg::REG_COEF_A1:     cfg_d.coef_a1     = pwdata[lcp_pkg::COEF_W-1:0];
        lcp_pkg::REG_COEF_A2:     cfg_d.coef_a2     = pwdata[lcp_pkg::COEF_W-1:0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint    <= '0;
      cfg_q.closed_loop <= 1'b0;
      cfg_q.drive       <= '0;
      cfg_q.coef_b0     <= 16'sd7799;
      cfg_q.coef_b1     <= 16'sd967;
      cfg_q.coef_b2     <= -16'sd6832;
      cfg_q.coef_a1     <= -16'sd26886;
      cfg_q.coef_a2     <= 16'sd10502;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux, coefficients sign extended
  always_comb begin
    case (idx)
      lcp_pkg::REG_SETPOINT:    prdata = lcp_pkg::DATA_W'(cfg_q.setpoint);
      lcp_pkg::REG_CLOSED_LOOP: prdata = lcp_pkg::DATA_W'(cfg_q.closed_loop);
      lcp_pkg::REG_DRIVE:       prdata = lcp_pkg::DATA_W'(cfg_q.drive);
      lcp_pkg::REG_COEF_B0:     prdata = lcp_pkg::DATA_W'(cfg_q.coef_b0);
      lcp_pkg::REG_COEF_B1:     prdata = lcp_pkg::DATA_W'(cfg_q.coef_b1);
      lcp_pkg::REG_COEF_B2:     prdata = lcp_pkg::DATA_W'(cfg_q.coef_b2);
      lcp_pkg::REG_COEF_A1:     prdata = lcp_pkg::DATA_W'(cfg_q.coef_a1);
      lcp_pkg::REG_COEF_A2:     prdata = lcp_pkg::DATA_W'(cfg_q.coef_a2);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/lcp_dp.sv
module lcp_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcp_pkg::cfg_t                cfg_i,
  input  lcp_pkg::dp_cmd_t             cmd_i,
  input  logic [lcp_pkg::SAMPLE_W-1:0] sample_i,
  output logic [lcp_pkg::DUTY_W-1:0]   duty_o,
  output logic                         clamped_o
);

  logic [lcp_pkg::SAMPLE_W-1:0]      sample_q;
  logic signed [lcp_pkg::ERR_W-1:0]  err_cur;
  logic signed [lcp_pkg::ERR_W-1:0]  err1_q, err2_q;
  logic signed [lcp_pkg::CMD_W-1:0]  cmd1_q, cmd2_q;
  logic signed [lcp_pkg::CMD_W-1:0]  cmd_q;
  logic signed [lcp_pkg::CMD_W-1:0]  cmd_sat;
  logic signed [lcp_pkg::MUL_A_W-1:0] op_a;
  logic signed [lcp_pkg::MUL_B_W-1:0] op_b;
  logic signed [lcp_pkg::PROD_W-1:0] product_q;
  logic                              prod_b_q;
  logic signed [lcp_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic signed [lcp_pkg::ACC_W-1:0]  prod_ext;
  logic [lcp_pkg::ACC_W-lcp_pkg::COEF_FRAC_BITS-lcp_pkg::CMD_W:0] acc_hi;
  logic signed [lcp_pkg::Q_W-1:0]    quot;
  logic [lcp_pkg::SCALE_SHIFT-1:0]   rem;
  logic [lcp_pkg::DUTY_W-1:0]        duty_d, duty_q;
  logic                              clamped_d, clamped_q;

  // sample capture and current error
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_load) begin
      sample_q <= sample_i;
    end
  end

  assign err_cur = $signed({1'b0, cfg_i.setpoint}) - $signed({1'b0, sample_q});

  // shared multiplier operand select
  always_comb begin
    case (cmd_i.mul_sel)
      lcp_pkg::MUL_B0: begin
        op_a = lcp_pkg::MUL_A_W'(cfg_i.coef_b0);
        op_b = lcp_pkg::MUL_B_W'(err_cur);
      end
      lcp_pkg::MUL_B1: begin
        op_a = lcp_pkg::MUL_A_W'(cfg_i.coef_b1);
        op_b = lcp_pkg::MUL_B_W'(err1_q);
      end
      lcp_pkg::MUL_B2: begin
        op_a = lcp_pkg::MUL_A_W'(cfg_i.coef_b2);
        op_b = lcp_pkg::MUL_B_W'(err2_q);
      end
      lcp_pkg::MUL_A1: begin
        op_a = lcp_pkg::MUL_A_W'(cfg_i.coef_a1);
        op_b = cmd1_q;
      end
      lcp_pkg::MUL_A2: begin
        op_a = lcp_pkg::MUL_A_W'(cfg_i.coef_a2);
        op_b = cmd2_q;
      end
      lcp_pkg::MUL_SCALE: begin
        op_a = lcp_pkg::MUL_A_W'(lcp_pkg::PWM_PERIOD);
        op_b = cmd_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // product register, tagged with numerator or denominator tap
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      product_q <= op_a * op_b;
      prod_b_q  <= (cmd_i.mul_sel == lcp_pkg::MUL_B0) ||
                   (cmd_i.mul_sel == lcp_pkg::MUL_B1) ||
                   (cmd_i.mul_sel == lcp_pkg::MUL_B2);
    end
  end

  // accumulator: numerator terms scaled up, denominator terms subtracted
  assign prod_ext = lcp_pkg::ACC_W'(product_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (cmd_i.acc_add) begin
      if (prod_b_q) begin
        acc_d = acc_q + (prod_ext <<< lcp_pkg::COEF_FRAC_BITS);
      end else begin
        acc_d = acc_q - prod_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // floor shift and saturate to the command width
  assign acc_hi = acc_q[lcp_pkg::ACC_W-1:lcp_pkg::COEF_FRAC_BITS+lcp_pkg::CMD_W-1];

  always_comb begin
    if ((&acc_hi) || !(|acc_hi)) begin
      cmd_sat = acc_q[lcp_pkg::COEF_FRAC_BITS+lcp_pkg::CMD_W-1:lcp_pkg::COEF_FRAC_BITS];
    end else if (acc_q[lcp_pkg::ACC_W-1]) begin
      cmd_sat = {1'b1, {(lcp_pkg::CMD_W-1){1'b0}}};
    end else begin
      cmd_sat = {1'b0, {(lcp_pkg::CMD_W-1){1'b1}}};
    end
  end

  // current command
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd_from_acc) begin
      cmd_q <= cmd_sat;
    end else if (cmd_i.cmd_from_drive) begin
      cmd_q <= lcp_pkg::CMD_W'(cfg_i.drive) <<< lcp_pkg::COEF_FRAC_BITS;
    end
  end

  // error and command history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err1_q <= '0;
      err2_q <= '0;
      cmd1_q <= '0;
      cmd2_q <= '0;
    end else if (cmd_i.hist_clear) begin
      err1_q <= '0;
      err2_q <= '0;
      cmd1_q <= '0;
      cmd2_q <= '0;
    end else if (cmd_i.hist_update) begin
      err1_q <= err_cur;
      err2_q <= err1_q;
      cmd1_q <= cmd_sat;
      cmd2_q <= cmd1_q;
    end
  end

  // duty from scaled command: floor quotient, clamp to limits
  assign quot = product_q[lcp_pkg::PROD_W-1:lcp_pkg::SCALE_SHIFT];
  assign rem  = product_q[lcp_pkg::SCALE_SHIFT-1:0];

  always_comb begin
    if (quot < lcp_pkg::Q_W'(lcp_pkg::DUTY_MIN)) begin
      duty_d    = lcp_pkg::DUTY_W'(lcp_pkg::DUTY_MIN);
      clamped_d = 1'b1;
    end else if ((quot > lcp_pkg::Q_W'(lcp_pkg::PWM_PERIOD)) ||
                 ((quot == lcp_pkg::Q_W'(lcp_pkg::PWM_PERIOD)) && (rem != '0))) begin
      duty_d    = lcp_pkg::DUTY_W'(lcp_pkg::PWM_PERIOD);
      clamped_d = 1'b1;
    end else begin
      duty_d    = quot[lcp_pkg::DUTY_W-1:0];
      clamped_d = 1'b0;
    end
  end

  // output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      duty_q    <= duty_d;
      clamped_q <= clamped_d;
    end
  end

  assign duty_o    = duty_q;
  assign clamped_o = clamped_q;

endmodule

FILE: sv/lcp_ctrl.sv
module lcp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              closed_loop_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lcp_pkg::dp_cmd_t  cmd_o
);

  lcp_pkg::state_e             state_q, state_d;
  logic [lcp_pkg::TAP_W-1:0]   tap_q, tap_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    case (state_q)
      lcp_pkg::ST_IDLE: begin
        tap_d = '0;
        if (in_valid_i) begin
          state_d = closed_loop_i ? lcp_pkg::ST_MAC : lcp_pkg::ST_SCALE;
        end
      end
      lcp_pkg::ST_MAC: begin
        if (tap_q == lcp_pkg::TAP_LAST) begin
          state_d = lcp_pkg::ST_FLUSH;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      lcp_pkg::ST_FLUSH: state_d = lcp_pkg::ST_SAT;
      lcp_pkg::ST_SAT:   state_d = lcp_pkg::ST_SCALE;
      lcp_pkg::ST_SCALE: state_d = lcp_pkg::ST_DONE;
      lcp_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lcp_pkg::ST_IDLE;
        end
      end
      default: state_d = lcp_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = lcp_pkg::MUL_B0;
    case (state_q)
      lcp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.sample_load = 1'b1;
          cmd_o.acc_clr     = 1'b1;
          if (!closed_loop_i) begin
            cmd_o.cmd_from_drive = 1'b1;
            cmd_o.hist_clear     = 1'b1;
          end
        end
      end
      lcp_pkg::ST_MAC: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcp_pkg::mul_sel_e'(tap_q);
        cmd_o.acc_add = (tap_q != '0);
      end
      lcp_pkg::ST_FLUSH: cmd_o.acc_add = 1'b1;
      lcp_pkg::ST_SAT: begin
        cmd_o.cmd_from_acc = 1'b1;
        cmd_o.hist_update  = 1'b1;
      end
      lcp_pkg::ST_SCALE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = lcp_pkg::MUL_SCALE;
      end
      lcp_pkg::ST_DONE: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  assign in_stall_o  = (state_q != lcp_pkg::ST_IDLE);
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcp_pkg::ST_IDLE;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/lcp_checker.sv
`include "lead_compensator_pwm_assert.svh"

module lcp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [lcp_pkg::DUTY_W-1:0] duty_o,
  input logic                       clamped_o
);

  logic duty_in_range;

  assign duty_in_range = (duty_o >= lcp_pkg::DUTY_W'(lcp_pkg::DUTY_MIN)) &&
                         (duty_o <= lcp_pkg::DUTY_W'(lcp_pkg::PWM_PERIOD));

  // duty always within the pwm limits
  `LCP_ASSERT_NOW(a_duty_range, out_valid_o, duty_in_range)

  // one sample in flight: busy right after a sample beat
  `LCP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // a new result only comes out of a busy block
  `LCP_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(in_stall_o))

  // stalled result beat holds
  `LCP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable({duty_o, clamped_o}))

endmodule

bind lead_compensator_pwm lcp_checker u_lcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .duty_o      (duty_o),
  .clamped_o   (clamped_o)
);
